// ===== src/cgpg_pkg.sv =====
package cgpg_pkg;

    // Field and register widths
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 3;
    localparam int LEVEL_W    = 8;
    localparam int HUE_W      = 9;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam int MAX_DIM       = 4096;
    localparam int RESET_DIM     = 1024;
    localparam int DEF_FRAC_BITS = 16;

    localparam int HUE_WRAP   = 360;
    localparam int HUE_SECTOR = 60;
    localparam int BYTE_MAX   = 255;

    // gradient modes
    localparam logic [MODE_W-1:0] MODE_RED   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GREEN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLUE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HUE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SAT   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_VAL   = 3'd5;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HUE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 3'd4;

    // input stage + one stage per quotient bit + four color stages
    function automatic int stage_count(input int frac_bits);
        return frac_bits + 8;
    endfunction

endpackage

// ===== src/cgpg_div_lane.sv =====
module cgpg_div_lane #(
    parameter int NW = 31,
    parameter int QW = 19,
    parameter int DW = 13
) (
    input  logic          clk,
    input  logic [QW-1:0] en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient
);
    import cgpg_pkg::*;

    // restoring division, one quotient bit per stage, MSB first
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] low_next [QW];
    logic [QW-1:0] quo_next [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] quo_in;
            logic [DW:0]   trial;
            logic          take;

            if (s == 0)
            begin : g_first
                // upper dividend bits are below the divisor since quotient < 2^QW
                assign rem_in = DW'(dividend[NW-1:QW]);
                assign low_in = dividend[QW-1:0];
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1];
                assign low_in = low_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            assign trial       = {rem_in, low_in[QW-1]};
            assign take        = (trial >= {1'b0, divisor});
            assign rem_next[s] = take ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            assign low_next[s] = low_in << 1;
            assign quo_next[s] = {quo_in[QW-2:0], take};

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next[s];
                    low_reg[s] <= low_next[s];
                    quo_reg[s] <= quo_next[s];
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[QW-1];

endmodule

// ===== src/color_gradient_pattern_generator_unit.sv =====
// Channel   Dir  Payload (low bit up)                     Handshake
// s_*       in   tdata: col[11:0], row[23:12]              tvalid/tready
// m_*       out  tdata: pix_red[7:0], pix_green[15:8],     tvalid/tready
//                pix_blue[23:16]
// cfg_*     in   addr: register index, wdata: value        cfg_we, no wait
//
// One word per clock sustained while m_tready is high. FRAC_BITS+8 register
// stages (24 at the default): clamp/dividend stage, FRAC_BITS+3 divider
// stages retiring one quotient bit each, four color stages.
// rst_n clears the valid bits and loads the register defaults; no clearing pass.
// A stage holds only while every stage after it is full, so bubbles close up
// and s_tready stays high whenever m_tready is high.
// Config is sampled live by the pipeline: write it only while the block is idle.
module color_gradient_pattern_generator_unit #(
    parameter int FRAC_BITS = cgpg_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*cgpg_pkg::COORD_W-1:0]    s_tdata,   // col, row
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [3*cgpg_pkg::BYTE_W-1:0]     m_tdata,   // pix_red, pix_green, pix_blue
    input  logic                              cfg_we,
    input  logic [cgpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cgpg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import cgpg_pkg::*;

    localparam int QW = FRAC_BITS + 3;       // quotient bits: hue position <= 6.0
    localparam int NW = COORD_W + QW;        // dividend bits
    localparam int UW = FRAC_BITS + 1;       // unit values 0 .. 1.0
    localparam int NS = stage_count(FRAC_BITS);
    localparam int HS = QW + 1;              // first color stage
    localparam logic [UW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        priority if (d < DIM_W'(2))
            r = DIM_W'(2);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = d;
        return r;
    endfunction

    // v * 255 / ONE, truncated
    function automatic logic [BYTE_W-1:0] to_byte(input logic [UW-1:0] v);
        logic [UW+BYTE_W-1:0] p;
        p = {v, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, v};
        return p[FRAC_BITS +: BYTE_W];
    endfunction

    //------------------------------------------------------------------
    // Configuration registers (dims stored clamped, hue stored mod 360)
    //------------------------------------------------------------------
    logic [MODE_W-1:0]  mode_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [HUE_W-1:0]   hue_reg;
    logic [DIM_W-1:0]   w_reg, wm1_reg, h_reg, hm1_reg;
    logic [DIM_W-1:0]   wr_dim;
    logic [HUE_W-1:0]   wr_hue_raw, wr_hue;

    assign wr_dim     = clamp_dim(cfg_wdata[DIM_W-1:0]);
    assign wr_hue_raw = cfg_wdata[HUE_W-1:0];
    assign wr_hue     = (wr_hue_raw >= HUE_W'(HUE_WRAP)) ? wr_hue_raw - HUE_W'(HUE_WRAP)
                                                         : wr_hue_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RED;
            level_reg <= '0;
            hue_reg   <= '0;
            w_reg     <= DIM_W'(RESET_DIM);
            wm1_reg   <= DIM_W'(RESET_DIM - 1);
            h_reg     <= DIM_W'(RESET_DIM);
            hm1_reg   <= DIM_W'(RESET_DIM - 1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MODE:   mode_reg  <= cfg_wdata[MODE_W-1:0];
                CFG_LEVEL:  level_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_HUE:    hue_reg   <= wr_hue;
                CFG_WIDTH:
                begin
                    w_reg   <= wr_dim;
                    wm1_reg <= wr_dim - DIM_W'(1);
                end
                CFG_HEIGHT:
                begin
                    h_reg   <= wr_dim;
                    hm1_reg <= wr_dim - DIM_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Divisor per lane, per mode. Registered: first used one stage after entry.
    //   lane c: col*255/w | col*ONE/(w-1) | level*ONE/255
    //   lane r: row*255/h | row*ONE/(h-1)
    //   lane a: hue*ONE/60 | col*6*ONE/(w-1)
    logic [DIM_W-1:0] dvs_c_next, dvs_r_next, dvs_a_next;
    logic [DIM_W-1:0] dvs_c_reg, dvs_r_reg, dvs_a_reg;

    always_comb
    begin
        unique case (mode_reg)
            MODE_RED, MODE_GREEN, MODE_BLUE:
            begin
                dvs_c_next = w_reg;
                dvs_r_next = h_reg;
                dvs_a_next = wm1_reg;
            end
            MODE_HUE:
            begin
                dvs_c_next = wm1_reg;
                dvs_r_next = hm1_reg;
                dvs_a_next = DIM_W'(HUE_SECTOR);
            end
            MODE_SAT, MODE_VAL:
            begin
                dvs_c_next = DIM_W'(BYTE_MAX);
                dvs_r_next = hm1_reg;
                dvs_a_next = wm1_reg;
            end
            default:
            begin
                dvs_c_next = wm1_reg;
                dvs_r_next = hm1_reg;
                dvs_a_next = wm1_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dvs_c_reg <= dvs_c_next;
        dvs_r_reg <= dvs_r_next;
        dvs_a_reg <= dvs_a_next;
    end

    //------------------------------------------------------------------
    // Stage control: a stage moves when the output is taken or any stage
    // from it onward holds a bubble
    //------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    genvar gs;
    generate
        for (gs = 0; gs < NS; gs++)
        begin : g_en
            assign en[gs] = m_tready | ~(&vld_reg[NS-1:gs]);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NS-1];

    //------------------------------------------------------------------
    // Stage 0: clamp coordinates, build dividends
    //------------------------------------------------------------------
    logic [COORD_W-1:0] col_in, row_in, col_cl, row_cl;
    logic [NW-1:0]      dvd_c_next, dvd_r_next, dvd_a_next;
    logic [NW-1:0]      dvd_c_reg, dvd_r_reg, dvd_a_reg;
    logic [NW-1:0]      col_ext, row_ext;

    assign col_in  = s_tdata[COORD_W-1:0];
    assign row_in  = s_tdata[2*COORD_W-1:COORD_W];
    assign col_cl  = (col_in > wm1_reg[COORD_W-1:0]) ? wm1_reg[COORD_W-1:0] : col_in;
    assign row_cl  = (row_in > hm1_reg[COORD_W-1:0]) ? hm1_reg[COORD_W-1:0] : row_in;
    assign col_ext = NW'(col_cl);
    assign row_ext = NW'(row_cl);

    always_comb
    begin
        unique case (mode_reg)
            MODE_RED, MODE_GREEN, MODE_BLUE:
            begin
                dvd_c_next = (col_ext << BYTE_W) - col_ext;
                dvd_r_next = (row_ext << BYTE_W) - row_ext;
                dvd_a_next = '0;
            end
            MODE_HUE:
            begin
                dvd_c_next = col_ext << FRAC_BITS;
                dvd_r_next = row_ext << FRAC_BITS;
                dvd_a_next = NW'(hue_reg) << FRAC_BITS;
            end
            MODE_SAT, MODE_VAL:
            begin
                dvd_c_next = NW'(level_reg) << FRAC_BITS;
                dvd_r_next = row_ext << FRAC_BITS;
                dvd_a_next = ((col_ext << 2) + (col_ext << 1)) << FRAC_BITS;
            end
            default:
            begin
                dvd_c_next = '0;
                dvd_r_next = '0;
                dvd_a_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dvd_c_reg <= dvd_c_next;
            dvd_r_reg <= dvd_r_next;
            dvd_a_reg <= dvd_a_next;
        end
    end

    //------------------------------------------------------------------
    // Stages 1..QW: divider lanes
    //------------------------------------------------------------------
    logic [QW-1:0] q_c, q_r, q_a;

    cgpg_div_lane #(.NW(NW), .QW(QW), .DW(DIM_W)) u_div_c
    (
        .clk      (clk),
        .en       (en[QW:1]),
        .dividend (dvd_c_reg),
        .divisor  (dvs_c_reg),
        .quotient (q_c)
    );

    cgpg_div_lane #(.NW(NW), .QW(QW), .DW(DIM_W)) u_div_r
    (
        .clk      (clk),
        .en       (en[QW:1]),
        .dividend (dvd_r_reg),
        .divisor  (dvs_r_reg),
        .quotient (q_r)
    );

    cgpg_div_lane #(.NW(NW), .QW(QW), .DW(DIM_W)) u_div_a
    (
        .clk      (clk),
        .en       (en[QW:1]),
        .dividend (dvd_a_reg),
        .divisor  (dvs_a_reg),
        .quotient (q_a)
    );

    //------------------------------------------------------------------
    // H1: sector, ramp, chroma C = S*V
    //------------------------------------------------------------------
    logic [UW-1:0]       sat_u, val_u, t_next;
    logic [2:0]          k_raw, k_next;
    logic [FRAC_BITS-1:0] frac_a;
    logic [2*UW-1:0]     sv_prod;
    logic [UW-1:0]       h1_c_reg, h1_t_reg, h1_v_reg;
    logic [2:0]          h1_k_reg;
    logic [BYTE_W-1:0]   h1_row_reg, h1_col_reg;

    always_comb
    begin
        unique case (mode_reg)
            MODE_VAL:
            begin
                sat_u = q_r[UW-1:0];
                val_u = q_c[UW-1:0];
            end
            default:
            begin
                sat_u = q_c[UW-1:0];
                val_u = q_r[UW-1:0];
            end
        endcase
    end

    assign k_raw   = q_a[QW-1:FRAC_BITS];
    assign frac_a  = q_a[FRAC_BITS-1:0];
    assign k_next  = (k_raw >= 3'd6) ? 3'd0 : k_raw;
    assign t_next  = k_next[0] ? ONE - {1'b0, frac_a} : {1'b0, frac_a};
    assign sv_prod = sat_u * val_u;

    always_ff @(posedge clk)
    begin
        if (en[HS])
        begin
            h1_c_reg   <= sv_prod[FRAC_BITS +: UW];
            h1_t_reg   <= t_next;
            h1_v_reg   <= val_u;
            h1_k_reg   <= k_next;
            h1_row_reg <= q_r[BYTE_W-1:0];
            h1_col_reg <= q_c[BYTE_W-1:0];
        end
    end

    //------------------------------------------------------------------
    // H2: X = C*t, m = V - C
    //------------------------------------------------------------------
    logic [2*UW-1:0]   ct_prod;
    logic [UW-1:0]     h2_x_reg, h2_m_reg, h2_v_reg;
    logic [2:0]        h2_k_reg;
    logic [BYTE_W-1:0] h2_row_reg, h2_col_reg;

    assign ct_prod = h1_c_reg * h1_t_reg;

    always_ff @(posedge clk)
    begin
        if (en[HS+1])
        begin
            h2_x_reg   <= ct_prod[FRAC_BITS +: UW];
            h2_m_reg   <= h1_v_reg - h1_c_reg;
            h2_v_reg   <= h1_v_reg;
            h2_k_reg   <= h1_k_reg;
            h2_row_reg <= h1_row_reg;
            h2_col_reg <= h1_col_reg;
        end
    end

    //------------------------------------------------------------------
    // H3: sector select
    //------------------------------------------------------------------
    logic [UW-1:0]     xm;
    logic [UW-1:0]     r3_next, g3_next, b3_next;
    logic [UW-1:0]     h3_r_reg, h3_g_reg, h3_b_reg;
    logic [BYTE_W-1:0] h3_row_reg, h3_col_reg;

    assign xm = h2_x_reg + h2_m_reg;

    always_comb
    begin
        unique case (h2_k_reg)
            3'd0:    begin r3_next = h2_v_reg; g3_next = xm;       b3_next = h2_m_reg; end
            3'd1:    begin r3_next = xm;       g3_next = h2_v_reg; b3_next = h2_m_reg; end
            3'd2:    begin r3_next = h2_m_reg; g3_next = h2_v_reg; b3_next = xm;       end
            3'd3:    begin r3_next = h2_m_reg; g3_next = xm;       b3_next = h2_v_reg; end
            3'd4:    begin r3_next = xm;       g3_next = h2_m_reg; b3_next = h2_v_reg; end
            default: begin r3_next = h2_v_reg; g3_next = h2_m_reg; b3_next = xm;       end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[HS+2])
        begin
            h3_r_reg   <= r3_next;
            h3_g_reg   <= g3_next;
            h3_b_reg   <= b3_next;
            h3_row_reg <= h2_row_reg;
            h3_col_reg <= h2_col_reg;
        end
    end

    //------------------------------------------------------------------
    // H4: bytes and mode select, output register
    //------------------------------------------------------------------
    logic [BYTE_W-1:0] red_next, green_next, blue_next;
    logic [BYTE_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        unique case (mode_reg)
            MODE_RED:
            begin
                red_next   = level_reg;
                green_next = h3_row_reg;
                blue_next  = h3_col_reg;
            end
            MODE_GREEN:
            begin
                red_next   = h3_row_reg;
                green_next = level_reg;
                blue_next  = h3_col_reg;
            end
            MODE_BLUE:
            begin
                red_next   = h3_row_reg;
                green_next = h3_col_reg;
                blue_next  = level_reg;
            end
            MODE_HUE, MODE_SAT, MODE_VAL:
            begin
                red_next   = to_byte(h3_r_reg);
                green_next = to_byte(h3_g_reg);
                blue_next  = to_byte(h3_b_reg);
            end
            default:
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tdata = {blue_reg, green_reg, red_reg};

endmodule

// ===== src/cgpg_checker.sv =====
module cgpg_checker #(
    parameter int FRAC_BITS = cgpg_pkg::DEF_FRAC_BITS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [3*cgpg_pkg::BYTE_W-1:0] m_tdata
);
    import cgpg_pkg::*;

    localparam int NS = stage_count(FRAC_BITS);
    localparam int CW = $clog2(NS + 2) + 1;

    // words accepted but not yet delivered
    logic [CW-1:0] cnt_reg, cnt_next;

    assign cnt_next = cnt_reg + CW'(s_tvalid && s_tready) - CW'(m_tvalid && m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt_reg != '0)
        else $error("output word with nothing in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(NS))
        else $error("more words in flight than pipeline stages");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

endmodule

bind color_gradient_pattern_generator_unit cgpg_checker #(.FRAC_BITS(FRAC_BITS)) u_cgpg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
